@@ rtl/bba_pkg.sv @@
// Shared constants and controller/datapath handshake structs for the block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  // Map word geometry: blocks are tracked 32 to a memory word.
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Fixed field widths on the channels.
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  // Request codes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic clr;           // clearing pass: write zero at ptr, advance ptr
    logic load_req;      // latch incoming request word
    logic start_alloc;   // ptr <= hint
    logic rd_alloc;      // read map word at ptr
    logic rd_free;       // read map word holding the request index
    logic step;          // ptr <= ptr + 1
    logic commit_alloc;  // mark found bit used
    logic commit_free;   // clear the requested bit if set
    logic refuse;        // allocate refused, pool full
    logic skip;          // free index outside the pool
    logic load_out;      // move pending result into the output register
  } bba_cmd_t;

  typedef struct packed {
    logic ptr_last;      // ptr sits on the last map word
    logic req_free;      // latched request is a free
    logic idx_ok;        // latched index lies inside the pool
    logic pool_empty;    // free count is zero
    logic found;         // word at ptr has a free block
  } bba_stat_t;

endpackage : bba_pkg
`default_nettype wire

@@ rtl/bba_if.sv @@
// Valid/ready channel interfaces for allocator requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [9:0] block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink   (input valid, input mode, input block_index, output ready);
endinterface : bba_req_if

interface bba_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [9:0]  granted_index;
  logic        was_used;
  logic [10:0] free_count;

  modport source (output valid, output status, output granted_index, output was_used,
                  output free_count, input ready);
  modport sink   (input valid, input status, input granted_index, input was_used,
                  input free_count, output ready);
endinterface : bba_res_if
`default_nettype wire

@@ rtl/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : bba_ram
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
// Sequencing state machine for the block allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bba_stat_t stat,
  output bba_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ARD    = 3'd3;
  localparam logic [2:0] S_ACHK   = 3'd4;
  localparam logic [2:0] S_FRD    = 3'd5;
  localparam logic [2:0] S_FCHK   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req_free) begin
          if (stat.idx_ok) begin
            state_next = S_FRD;
          end else begin
            cmd.skip   = 1'b1;
            state_next = S_DONE;
          end
        end else if (stat.pool_empty) begin
          cmd.refuse = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.start_alloc = 1'b1;
          state_next      = S_ARD;
        end
      end
      S_ARD: begin
        cmd.rd_alloc = 1'b1;
        state_next   = S_ACHK;
      end
      S_ACHK: begin
        if (stat.found) begin
          cmd.commit_alloc = 1'b1;
          state_next       = S_DONE;
        end else if (stat.ptr_last) begin
          cmd.refuse = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_ARD;
        end
      end
      S_FRD: begin
        cmd.rd_free = 1'b1;
        state_next  = S_FCHK;
      end
      S_FCHK: begin
        cmd.commit_free = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A pending result is handed over as soon as the output slot opens.
  a_done_moves: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && slot_free |=> out_valid && state == S_IDLE)
    else $error("pending result not moved to output register");

  // No new request word is taken while a scan is in flight.
  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_ARD || state == S_ACHK) |-> !in_ready)
    else $error("request accepted during scan");

  // The clearing pass finishes before the first request is taken.
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_CLEAR && state != S_CLEAR |-> $past(stat.ptr_last))
    else $error("clearing pass left early");

endmodule : bba_ctrl
`default_nettype wire

@@ rtl/bba_dp.sv @@
// Allocator datapath: map memory, scan pointer, free count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bba_dp
  import bba_pkg::*;
#(
  parameter int POOL_BLOCKS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bba_cmd_t         cmd,
  output bba_stat_t             stat,
  input  wire logic             in_mode,
  input  wire logic [IDX_W-1:0] in_block_index,
  output logic                  out_status,
  output logic      [IDX_W-1:0] out_granted_index,
  output logic                  out_was_used,
  output logic      [CNT_W-1:0] out_free_count
);

  localparam int NUM_WORDS = (POOL_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GW        = WA_W + BIT_W;
  localparam int PCNT_W    = $clog2(POOL_BLOCKS + 1);
  localparam int LAST_BITS = POOL_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NUM_WORDS - 1);
  localparam logic [WORD_W:0]   ONE_EXT   = {{WORD_W{1'b0}}, 1'b1};
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((ONE_EXT << LAST_BITS) - ONE_EXT);
  localparam logic [PCNT_W-1:0] POOL_CNT  = PCNT_W'(POOL_BLOCKS);

  logic [WA_W-1:0]   ptr;
  logic [WA_W-1:0]   hint;
  logic [PCNT_W-1:0] count;
  logic              req_mode;
  logic [IDX_W-1:0]  req_idx;
  logic              res_status;
  logic [GW-1:0]     res_granted;
  logic              res_was_used;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] eff_word;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] low_free;
  logic [BIT_W-1:0]  low_pos;
  logic [WA_W-1:0]   free_word;
  logic [BIT_W-1:0]  free_pos;
  logic [WORD_W-1:0] free_mask;
  logic              bit_set;

  logic              ram_we;
  logic [WA_W-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WA_W-1:0]   ram_raddr;

  assign free_word = WA_W'(req_idx >> BIT_W);
  assign free_pos  = req_idx[BIT_W-1:0];
  assign free_mask = WORD_W'(ONE_EXT << free_pos);
  assign bit_set   = |(rd_data & free_mask);

  // Bits past the end of the pool in the last word read as used.
  assign eff_word  = rd_data | ((ptr == LAST_WORD) ? ~LAST_MASK : '0);
  assign free_bits = ~eff_word;
  assign low_free  = free_bits & (~free_bits + WORD_W'(1));

  always_comb begin
    low_pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_free[i]) low_pos = low_pos | BIT_W'(i);
    end
  end

  assign stat.ptr_last   = (ptr == LAST_WORD);
  assign stat.req_free   = (req_mode == MODE_FREE);
  assign stat.idx_ok     = (32'(req_idx) < 32'(POOL_BLOCKS));
  assign stat.pool_empty = (count == '0);
  assign stat.found      = |free_bits;

  assign ram_re    = cmd.rd_alloc || cmd.rd_free;
  assign ram_raddr = cmd.rd_free ? free_word : ptr;
  assign ram_we    = cmd.clr || cmd.commit_alloc || (cmd.commit_free && bit_set);
  assign ram_waddr = cmd.commit_free ? free_word : ptr;

  always_comb begin
    priority if (cmd.clr) begin
      ram_wdata = '0;
    end else if (cmd.commit_alloc) begin
      ram_wdata = rd_data | low_free;
    end else begin
      ram_wdata = rd_data & ~free_mask;
    end
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (WA_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Control state: scan pointer, lowest possibly non-full word, free count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      hint  <= '0;
      count <= POOL_CNT;
    end else begin
      if (cmd.clr) begin
        ptr <= (ptr == LAST_WORD) ? '0 : ptr + WA_W'(1);
      end else if (cmd.start_alloc) begin
        ptr <= hint;
      end else if (cmd.step) begin
        ptr <= ptr + WA_W'(1);
      end
      if (cmd.commit_alloc) begin
        hint  <= ptr;
        count <= count - PCNT_W'(1);
      end else if (cmd.commit_free && bit_set) begin
        count <= count + PCNT_W'(1);
        if (free_word < hint) hint <= free_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= in_mode;
      req_idx  <= in_block_index;
    end
    if (cmd.commit_alloc) begin
      res_status   <= STATUS_DONE;
      res_granted  <= {ptr, low_pos};
      res_was_used <= 1'b0;
    end else if (cmd.commit_free) begin
      res_status   <= STATUS_DONE;
      res_granted  <= '0;
      res_was_used <= bit_set;
    end else if (cmd.refuse) begin
      res_status   <= STATUS_FULL;
      res_granted  <= '0;
      res_was_used <= 1'b0;
    end else if (cmd.skip) begin
      res_status   <= STATUS_DONE;
      res_granted  <= '0;
      res_was_used <= 1'b0;
    end
    if (cmd.load_out) begin
      out_status        <= res_status;
      out_granted_index <= IDX_W'(res_granted);
      out_was_used      <= res_was_used;
      out_free_count    <= CNT_W'(count);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= POOL_CNT)
    else $error("free count above pool size");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_alloc |-> count != '0 ##1 count == $past(count) - PCNT_W'(1))
    else $error("allocate with empty pool or bad count update");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_free && bit_set |=> count == $past(count) + PCNT_W'(1))
    else $error("free of used block did not raise count");

endmodule : bba_dp
`default_nettype wire

@@ rtl/block_bitmap_allocator_top.sv @@
// Top level of the first-fit bitmap block allocator.
// First-fit block allocator over a pool of POOL_BLOCKS blocks. The used/free
// map lives in a RAM of 32-bit words with a registered read; a free count and
// a pointer to the lowest word that may still hold a free block sit in flops.
// After reset the block clears the map, one word per cycle, before req.ready
// rises. One request word is worked at a time: a free goes through decode, a
// map read and a check, then its result moves to res once the output register
// is free, and req.ready returns in the same cycle that the result appears.
// An allocate goes through decode and then a RAM read and a check for each map
// word it scans from the lowest-free-word pointer up to the first word with a
// free block. An allocate on an empty pool is refused at decode, with no scan.
// Results leave through an output register, so a new request can be taken while
// the last result waits on res.ready.
`timescale 1ns / 1ps
`default_nettype none
module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int POOL_BLOCKS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  bba_req_if.sink   req,
  bba_res_if.source res
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bba_dp #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (req.mode),
    .in_block_index    (req.block_index),
    .out_status        (res.status),
    .out_granted_index (res.granted_index),
    .out_was_used      (res.was_used),
    .out_free_count    (res.free_count)
  );

endmodule : block_bitmap_allocator_top
`default_nettype wire

@@ bench/bba_grant_checker.sv @@
// Result checker for the block allocator: tracks the map, predicts every result word and compares.
`timescale 1ns / 1ps
module bba_grant_checker
  import bba_pkg::*;
#(
  parameter int POOL_BLOCKS = 1024
) (
  input  logic clk,
  input  logic rst,
  bba_req_if   req,
  bba_res_if   res,
  output int   errors,
  output int   pending,
  output int   free_now,
  output int   refusals
);

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] granted_index;
    logic             was_used;
    logic [CNT_W-1:0] free_count;
  } grant_t;

  bit [POOL_BLOCKS-1:0] used_map = '0;
  int unsigned          free_total = POOL_BLOCKS;
  grant_t               owed_grants[$];

  initial begin
    errors   = 0;
    refusals = 0;
    pending  = 0;
    free_now = POOL_BLOCKS;
  end

  // Applies one request word to the shadow map and returns the result it should produce.
  function automatic grant_t serve_request(input logic mode, input logic [IDX_W-1:0] idx);
    grant_t      g;
    int unsigned blk;
    bit          hit;
    g   = '0;
    blk = 0;
    hit = 1'b0;
    g.status = STATUS_DONE;
    if (mode == MODE_ALLOC) begin
      for (int i = 0; i < POOL_BLOCKS && !hit; i++) begin
        if (!used_map[i]) begin
          blk = i;
          hit = 1'b1;
        end
      end
      // nonzero count but no clear bit is refused the same as an empty pool
      if (free_total != 0 && hit) begin
        used_map[blk]   = 1'b1;
        free_total      = free_total - 1;
        g.granted_index = blk[IDX_W-1:0];
      end else begin
        g.status = STATUS_FULL;
        refusals++;
      end
    end else if (idx < POOL_BLOCKS) begin
      g.was_used = used_map[idx];
      if (used_map[idx]) begin
        used_map[idx] = 1'b0;
        free_total    = free_total + 1;
      end
    end
    g.free_count = free_total[CNT_W-1:0];
    return g;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      used_map   = '0;
      free_total = POOL_BLOCKS;
      owed_grants.delete();
    end else begin
      // check before predicting: a result can never belong to the word taken this edge
      if (res.valid && res.ready) begin
        if (owed_grants.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, got status %0d index %0d",
                   $time, res.status, res.granted_index);
          $display("  was_used %0d free_count %0d", res.was_used, res.free_count);
        end else begin
          want = owed_grants.pop_front();
          check_field("status", want.status, res.status);
          check_field("granted_index", want.granted_index, res.granted_index);
          check_field("was_used", want.was_used, res.was_used);
          check_field("free_count", want.free_count, res.free_count);
        end
      end
      if (req.valid && req.ready)
        owed_grants.push_back(serve_request(req.mode, req.block_index));
    end
    pending  <= owed_grants.size();
    free_now <= free_total;
  end

endmodule

@@ bench/tb_block_bitmap_allocator_top.sv @@
// Testbench top: clock, reset, request stimulus and result back-pressure for the block allocator.
`timescale 1ns / 1ps
module tb_block_bitmap_allocator_top
  import bba_pkg::*;
();

  localparam int POOL         = 1024;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int errors;
  int pending;
  int free_now;
  int refusals;
  int cycles     = 0;
  int hold_asks  = 0;
  int holds_done = 0;
  int n_alloc    = 0;
  int n_free     = 0;
  bit quiet      = 1'b0;

  bba_req_if req ();
  bba_res_if res ();

  block_bitmap_allocator_top #(.POOL_BLOCKS(POOL)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  bba_grant_checker #(.POOL_BLOCKS(POOL)) grant_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res      (res),
    .errors   (errors),
    .pending  (pending),
    .free_now (free_now),
    .refusals (refusals)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none in the quiet tail.
  initial begin : result_side
    res.ready = 1'b0;
    forever begin
      if (holds_done < hold_asks) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic mode, input logic [IDX_W-1:0] idx);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= mode;
    req.block_index <= idx;
    do @(posedge clk); while (!req.ready);
    if (mode == MODE_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic wait_all_back();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // First fit keeps used blocks low, so most frees aim at the used region or just above it.
  function automatic logic [IDX_W-1:0] pick_free_index();
    int span;
    span = POOL - free_now + 16;
    if (span > POOL - 1 || $urandom_range(0, 7) == 0) span = POOL - 1;
    return IDX_W'($urandom_range(0, span));
  endfunction

  initial begin : stimulus
    int fill_refused;
    req.valid       = 1'b0;
    req.mode        = MODE_ALLOC;
    req.block_index = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // free of blocks never used, grants in order, double free, refill of a hole
    send_word(MODE_FREE, 10'd0);
    send_word(MODE_FREE, 10'd1023);
    send_word(MODE_ALLOC, 10'd1023);
    send_word(MODE_ALLOC, 10'd0);
    send_word(MODE_ALLOC, 10'h2aa);
    send_word(MODE_FREE, 10'd1);
    send_word(MODE_FREE, 10'd1);
    send_word(MODE_ALLOC, 10'h155);
    send_word(MODE_ALLOC, 10'd0);
    send_word(MODE_FREE, 10'd0);
    send_word(MODE_FREE, 10'd2);
    send_word(MODE_ALLOC, 10'd0);
    send_word(MODE_ALLOC, 10'd1023);
    send_word(MODE_FREE, 10'd1023);
    wait_all_back();

    // fill the pool with scattered frees, then keep asking until refused a few times
    fill_refused = 0;
    while (fill_refused < 6) begin
      if ($urandom_range(0, 31) == 0) begin
        send_word(MODE_FREE, pick_free_index());
      end else begin
        if (free_now == 0) fill_refused++;
        send_word(MODE_ALLOC, IDX_W'($urandom));
      end
    end
    wait_all_back();

    // mixed traffic while the result side stalls long enough to back up the block
    hold_asks++;
    repeat (60) begin
      if ($urandom_range(0, 1) == 0) send_word(MODE_ALLOC, IDX_W'($urandom));
      else send_word(MODE_FREE, pick_free_index());
    end

    // tail without any idling, mostly frees
    quiet = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 4) == 0) send_word(MODE_ALLOC, IDX_W'($urandom));
      else send_word(MODE_FREE, pick_free_index());
    end
    wait_all_back();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d allocate and %0d free words; %0d allocates were refused on a full pool.",
             n_alloc, n_free, refusals);
    $display("Covered double frees, a full pool, a %0d-cycle result stall and a no-idle tail.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/block_bitmap_allocator_top.sv
bench/bba_grant_checker.sv
bench/tb_block_bitmap_allocator_top.sv
